/* rtl/core/pps_pkg.sv */
// Shared types and constants for the PPS period servo.
package pps_pkg;

   localparam int RING_DEPTH_DEFAULT   = 32;
   localparam int DRIFT_WINDOW_DEFAULT = 16;

   localparam logic [31:0] NOMINAL_RESET = 32'd1000000000;
   localparam logic [28:0] WINDOW_RESET  = 29'd1000000;
   localparam logic [28:0] LIMIT_RESET   = 29'd1000000;
   localparam logic [29:0] ONE_SECOND    = 30'd1000000000;
   localparam logic [28:0] HALF_SECOND   = 29'd500000000;
   localparam logic [34:0] BASE_LIMIT    = 35'h400000000;
   // floor(2^61 / 1e9)
   localparam logic [31:0] RECIP_SECOND  = 32'd2305843009;

   localparam logic [1:0] REG_NOMINAL = 2'd0;
   localparam logic [1:0] REG_WINDOW  = 2'd1;
   localparam logic [1:0] REG_LIMIT   = 2'd2;

   localparam logic [1:0] MODE_START   = 2'd0;
   localparam logic [1:0] MODE_ACQUIRE = 2'd1;
   localparam logic [1:0] MODE_TRACK   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD,
      ST_DISPATCH,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_DIV,
      ST_FINISH,
      ST_WRITE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic mod_step;
      logic sum_clear;
      logic sum_rd;
      logic sum_acc;
      logic div_start;
      logic div_step;
      logic finish;
      logic write;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       mod_done;
      logic       sum_done;
      logic       div_done;
   } status_type;

endpackage

/* rtl/core/pps_if.sv */
// Valid/ready word channel interfaces.
interface pps_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] edge_time;
   modport source (output valid, output edge_time, input ready);
   modport sink   (input valid, input edge_time, output ready);
endinterface

interface pps_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] next_period;
   logic [1:0]  servo_mode;
   logic        servo_reset;
   modport source (output valid, output next_period, output servo_mode,
                   output servo_reset, input ready);
   modport sink   (input valid, input next_period, input servo_mode,
                   input servo_reset, output ready);
endinterface

/* rtl/core/pps_ram.sv */
// Generic single-port-write, one-read RAM with registered read.
module pps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

/* rtl/core/pps_ctrl.sv */
// Servo sequencer state machine.
module pps_ctrl import pps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_done) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (status.mode == MODE_TRACK) begin
               cmd.sum_clear = 1'b1;
               state_in = ST_SUM_RD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SUM_RD: begin
            cmd.sum_rd = 1'b1;
            state_in = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            cmd.sum_acc = 1'b1;
            if (status.sum_done) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               state_in = ST_SUM_RD;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !rsp_ready) |=> state_ff == ST_OUT)
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_MOD)
      else $error("accept did not start the phase reduction");
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("accept while a result is pending");
endmodule

/* rtl/core/pps_datapath.sv */
// Servo datapath: phase reduction, rings, period sum, rounded divider.
module pps_datapath import pps_pkg::*; #(
   parameter int RING_DEPTH   = RING_DEPTH_DEFAULT,
   parameter int DRIFT_WINDOW = DRIFT_WINDOW_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [63:0] edge_time,
   input  logic [31:0] nominal_period,
   input  logic [28:0] lock_window,
   input  logic [28:0] error_limit,
   input  cmd_type     cmd,
   output status_type  status,
   output logic [31:0] next_period,
   output logic [1:0]  servo_mode,
   output logic        servo_reset
);
   localparam int AW = $clog2(RING_DEPTH);
   localparam int KW = $clog2(DRIFT_WINDOW + 3);

   // control state
   logic [1:0]    mode_ff, mode_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          full_ff, full_in;

   // payload
   logic [63:0] t_ff;
   logic [63:0] rem_ff;
   logic [5:0]  mstep_ff;
   logic [34:0] qe_ff;
   logic signed [35:0] err_ff;
   logic [KW-1:0] k_ff, cnt_ff;
   logic [36:0] sum_ff;
   logic [63:0] elapsed_ff;
   logic [127:0] num_ff;
   logic [63:0]  r_ff;
   logic [35:0]  q_ff;
   logic         big_ff;
   logic [7:0]   dstep_ff;
   logic [31:0]  per_ff;
   logic         rst_ff;
   logic         wr_per_ff;
   logic         wr_time_ff;
   logic [1:0]   nmode_ff;
   logic [AW-1:0] nidx_ff;
   logic          nfull_ff;
   logic [31:0]   p1_ff;

   // rings
   logic          p_we, t_we;
   logic [AW-1:0] p_wa, p_ra, t_ra;
   logic [31:0]   p_wd, p_rd;
   logic [63:0]   t_rd;

   pps_ram #(.WIDTH(32), .DEPTH(RING_DEPTH)) u_pring (
      .clock, .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd));
   pps_ram #(.WIDTH(64), .DEPTH(RING_DEPTH)) u_tring (
      .clock, .wr_en(t_we), .wr_addr(idx_ff), .wr_data(t_ff),
      .rd_addr(t_ra), .rd_data(t_rd));

   function automatic logic [AW-1:0] ring_add(logic [AW-1:0] a, int unsigned b);
      logic [AW:0] s;
      s = {1'b0, a} + (AW+1)'(b);
      if (s >= (AW+1)'(RING_DEPTH)) s = s - (AW+1)'(RING_DEPTH);
      return s[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] ring_sub(logic [AW-1:0] a, logic [KW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + (AW+1)'(RING_DEPTH) - (AW+1)'(b);
      if (s >= (AW+1)'(RING_DEPTH)) s = s - (AW+1)'(RING_DEPTH);
      return s[AW-1:0];
   endfunction

   logic full_now;
   assign full_now = full_ff || ({{(32-AW){1'b0}}, idx_ff} > 32'(DRIFT_WINDOW));

   // quotient estimate from the top word, never above the true quotient
   logic [63:0] recip_prod;
   logic [63:0] qe_back;
   assign recip_prod = 64'(t_ff[63:32]) * 64'(RECIP_SECOND);
   assign qe_back    = 64'(qe_ff) * 64'(ONE_SECOND);

   // read address: period window walk, then period ahead
   always_comb begin
      if (cmd.sum_rd && cnt_ff == k_ff) p_ra = ring_add(idx_ff, 1);
      else                              p_ra = ring_sub(idx_ff, cnt_ff);
      t_ra = ring_sub(idx_ff, k_ff);
   end

   // restoring division step values
   logic [64:0] r_sh;
   logic [65:0] r_diff;
   assign r_sh   = {r_ff, num_ff[127]};
   assign r_diff = {1'b0, r_sh} - {2'b0, elapsed_ff};

   // finish arithmetic
   logic [35:0] base_c;
   logic signed [37:0] err_new, per_raw;
   logic [36:0] abs_err;
   logic [64:0] twice_r;
   always_comb begin
      twice_r = {r_ff, 1'b0};
      base_c = q_ff;
      if (twice_r >= {1'b0, elapsed_ff}) base_c = q_ff + 36'd1;
      if (big_ff || base_c > {1'b0, BASE_LIMIT}) base_c = {1'b0, BASE_LIMIT};
      err_new = 38'(err_ff) + $signed({6'b0, p1_ff}) - $signed({2'b0, base_c});
      per_raw = $signed({2'b0, base_c}) - err_new;
      abs_err = err_new[37] ? 37'(-err_new) : 37'(err_new);
   end

   logic signed [34:0] acq_raw;
   logic [35:0] acq_abs;
   assign acq_raw = $signed({3'b0, nominal_period}) - 35'(err_ff);
   assign acq_abs = err_ff[35] ? 36'(-err_ff) : 36'(err_ff);

   function automatic logic [31:0] sat(logic signed [37:0] v);
      if (v < 0) return 32'd0;
      if (v > 38'sh0FFFFFFFF) return 32'hFFFFFFFF;
      return v[31:0];
   endfunction

   always_comb begin
      p_we = cmd.write && wr_per_ff;
      t_we = cmd.write && wr_time_ff;
      p_wd = per_ff;
      p_wa = (mode_ff == MODE_START || mode_ff == 2'd3) ? ring_add('0, 1)
                                                        : ring_add(idx_ff, 2);
   end

   always_comb begin
      mode_in = mode_ff;
      idx_in  = idx_ff;
      full_in = full_ff;
      if (cmd.commit) begin
         mode_in = nmode_ff;
         idx_in  = nidx_ff;
         full_in = nfull_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_START;
         idx_ff  <= '0;
         full_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         idx_ff  <= idx_in;
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         t_ff     <= edge_time;
         rem_ff   <= edge_time;
         mstep_ff <= '0;
      end
      // mod 1e9: reciprocal quotient estimate (at most 13 low), multiply
      // back, then compare-subtract 8e9, 4e9, 2e9, 1e9, then fold
      if (cmd.mod_step) begin
         if (mstep_ff == 6'd0) begin
            qe_ff <= recip_prod[63:29];
         end else if (mstep_ff == 6'd1) begin
            rem_ff <= t_ff - qe_back;
         end else if (mstep_ff <= 6'd5) begin
            if (rem_ff >= (64'(ONE_SECOND) << (5 - mstep_ff)))
               rem_ff <= rem_ff - (64'(ONE_SECOND) << (5 - mstep_ff));
         end else begin
            if (rem_ff[29:0] > 30'(HALF_SECOND))
               err_ff <= 36'(rem_ff[29:0]) - 36'(ONE_SECOND);
            else
               err_ff <= 36'(rem_ff[29:0]);
         end
         if (mstep_ff <= 6'd5) mstep_ff <= mstep_ff + 6'd1;
      end
      if (cmd.sum_clear) begin
         k_ff   <= full_now ? KW'(DRIFT_WINDOW) : KW'(1);
         cnt_ff <= '0;
         sum_ff <= '0;
      end
      if (cmd.sum_rd) cnt_ff <= cnt_ff + KW'(1);
      if (cmd.sum_acc) begin
         if (cnt_ff == k_ff + KW'(1)) begin
            p1_ff      <= p_rd;
            elapsed_ff <= t_ff - t_rd;
         end else begin
            sum_ff <= sum_ff + 37'(p_rd);
         end
      end
      if (cmd.div_start) begin
         num_ff   <= 128'(sum_ff) * 128'(ONE_SECOND);
         r_ff     <= '0;
         q_ff     <= '0;
         big_ff   <= 1'b0;
         dstep_ff <= '0;
      end
      if (cmd.div_step && dstep_ff < 8'd128) begin
         num_ff   <= {num_ff[126:0], 1'b0};
         dstep_ff <= dstep_ff + 8'd1;
         if (!r_diff[65]) begin
            r_ff <= r_diff[63:0];
            if (dstep_ff <= 8'd92) big_ff <= 1'b1;
            else q_ff <= {q_ff[34:0], 1'b1};
         end else begin
            r_ff <= r_sh[63:0];
            if (dstep_ff > 8'd92) q_ff <= {q_ff[34:0], 1'b0};
         end
      end
      if (cmd.finish) begin
         wr_per_ff  <= 1'b0;
         wr_time_ff <= 1'b0;
         rst_ff     <= 1'b0;
         per_ff     <= nominal_period;
         nmode_ff   <= mode_ff;
         nidx_ff    <= idx_ff;
         nfull_ff   <= full_ff;
         case (mode_ff)
            MODE_ACQUIRE: begin
               if (acq_abs < 36'(lock_window)) begin
                  wr_per_ff  <= 1'b1;
                  wr_time_ff <= 1'b1;
                  nidx_ff    <= ring_add(idx_ff, 1);
                  nmode_ff   <= MODE_TRACK;
               end else begin
                  per_ff   <= sat(38'(acq_raw));
                  nmode_ff <= MODE_START;
               end
            end
            MODE_TRACK: begin
               wr_time_ff <= 1'b1;
               if (elapsed_ff == '0 || abs_err > 37'(error_limit)) begin
                  rst_ff   <= 1'b1;
                  nmode_ff <= MODE_START;
                  nidx_ff  <= '0;
                  nfull_ff <= 1'b0;
                  wr_per_ff <= (elapsed_ff != '0);
                  per_ff   <= (elapsed_ff != '0) ? sat(per_raw) : nominal_period;
               end else begin
                  wr_per_ff <= 1'b1;
                  per_ff   <= sat(per_raw);
                  nidx_ff  <= ring_add(idx_ff, 1);
                  nfull_ff <= (k_ff != KW'(1)) || full_now;
               end
            end
            default: begin
               wr_per_ff <= 1'b1;
               nmode_ff  <= MODE_ACQUIRE;
            end
         endcase
      end
   end

   assign status.mode     = mode_ff;
   assign status.mod_done = (mstep_ff > 6'd5);
   assign status.sum_done = (cnt_ff == k_ff + KW'(2));
   assign status.div_done = (dstep_ff == 8'd128);

   assign next_period = rst_ff ? nominal_period : per_ff;
   assign servo_mode  = nmode_ff;
   assign servo_reset = rst_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.commit && servo_reset |=> mode_ff == MODE_START && idx_ff == '0)
      else $error("servo reset did not clear the index");
   assert property (@(posedge clock) disable iff (reset)
      mode_ff != 2'd3)
      else $error("unused mode reached");
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit && !servo_reset && mode_ff == MODE_TRACK |=> !(idx_ff == $past(idx_ff)))
      else $error("track step did not advance index");
endmodule

/* rtl/core/pps_period_servo.sv */
// Top level of the PPS period servo: register port, sequencer, datapath.
// Sequence: start/acquire words pass the phase reduction, finish, write and output
//   states; track words also pass k+2 ring reads, k = 1 or DRIFT_WINDOW, and the
//   restoring divider.
//   One word is processed at a time.
// A new word is accepted only after the previous result has been taken.
// Reset: synchronous, active high; mode start, index zero, registers to
//   their defaults. Ring contents stay undefined; they are written before read.
module pps_period_servo import pps_pkg::*; #(
   parameter int RING_DEPTH   = RING_DEPTH_DEFAULT,
   parameter int DRIFT_WINDOW = DRIFT_WINDOW_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   pps_req_if.sink     req,
   pps_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [31:0] nominal_ff;
   logic [28:0] window_ff;
   logic [28:0] limit_ff;
   logic        wr;
   logic [1:0]  reg_sel;

   assign csr_pready = 1'b1;
   assign wr      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         nominal_ff <= NOMINAL_RESET;
         window_ff  <= WINDOW_RESET;
         limit_ff   <= LIMIT_RESET;
      end else if (wr && csr_paddr[1:0] == 2'b00) begin
         case (reg_sel)
            REG_NOMINAL: nominal_ff <= csr_pwdata;
            REG_WINDOW:  window_ff  <= csr_pwdata[28:0];
            REG_LIMIT:   limit_ff   <= csr_pwdata[28:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_NOMINAL: csr_prdata = nominal_ff;
         REG_WINDOW:  csr_prdata = {3'b0, window_ff};
         REG_LIMIT:   csr_prdata = {3'b0, limit_ff};
         default:     csr_prdata = '0;
      endcase
   end

   cmd_type    cmd;
   status_type status;

   pps_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd, .status);

   pps_datapath #(.RING_DEPTH(RING_DEPTH), .DRIFT_WINDOW(DRIFT_WINDOW)) u_dp (
      .clock, .reset,
      .edge_time(req.edge_time),
      .nominal_period(nominal_ff),
      .lock_window(window_ff),
      .error_limit(limit_ff),
      .cmd, .status,
      .next_period(rsp.next_period),
      .servo_mode(rsp.servo_mode),
      .servo_reset(rsp.servo_reset));
endmodule

/* sim/pps_period_servo_tb.sv */
// Testbench for the PPS period servo: random and directed edge times, scoreboard check.
module pps_period_servo_tb;
   import pps_pkg::*;

   localparam int RING  = RING_DEPTH_DEFAULT;
   localparam int DRIFT = DRIFT_WINDOW_DEFAULT;

   // one expected result word
   typedef struct {
      logic [31:0] period;
      logic [1:0]  mode;
      logic        did_reset;
   } servo_word_type;

   // Scoreboard: a bit-exact predictor of the servo plus the queue of
   // words still owed by the block.
   class servo_scoreboard;
      logic [31:0] nominal;
      logic [28:0] lock_win;
      logic [28:0] err_limit;
      logic [1:0]  mode;
      int unsigned index;
      bit          full_win;
      logic [31:0] period_ring [RING];
      logic [63:0] time_ring [RING];
      servo_word_type owed [$];
      int          failures;

      function void clear_state();
         nominal = NOMINAL_RESET;
         lock_win = WINDOW_RESET;
         err_limit = LIMIT_RESET;
         mode = MODE_START;
         index = 0;
         full_win = 0;
         failures = 0;
         foreach (period_ring[i]) period_ring[i] = '0;
         foreach (time_ring[i]) time_ring[i] = '0;
      endfunction

      function void write_reg(logic [1:0] addr, logic [31:0] value);
         case (addr)
            REG_NOMINAL: begin
               nominal = value;
            end
            REG_WINDOW: begin
               lock_win = value[28:0];
            end
            REG_LIMIT: begin
               err_limit = value[28:0];
            end
            default: begin
            end
         endcase
      endfunction

      function logic [31:0] saturate(longint signed v);
         if (v < 0) return 32'd0;
         if (v > 64'sd4294967295) return 32'hFFFF_FFFF;
         return v[31:0];
      endfunction

      // round(num / d), clipped to BASE_LIMIT
      function logic [63:0] rounded_base(logic [127:0] num, logic [63:0] d);
         logic [127:0] q;
         logic [127:0] r;
         q = num / d;
         r = num % d;
         if (r >= {64'd0, d} - r) q = q + 1;
         if (q > BASE_LIMIT) q = BASE_LIMIT;
         return q[63:0];
      endfunction

      function void note_edge(logic [63:0] t);
         longint signed err;
         logic [31:0]   period;
         bit            did_reset;
         int unsigned   idx;
         bit            full;
         int unsigned   k;
         logic [63:0]   sum;
         logic [63:0]   elapsed;
         logic [63:0]   base;
         servo_word_type w;
         err = longint'(t % 64'd1000000000);
         period = nominal;
         did_reset = 0;
         idx = index % RING;
         if (err > 500000000) err -= 1000000000;
         if (mode == MODE_ACQUIRE) begin
            if ((err < 0 ? -err : err) < longint'(lock_win)) begin
               period_ring[(idx + 2) % RING] = nominal;
               time_ring[idx] = t;
               index = (idx + 1) % RING;
               mode = MODE_TRACK;
            end else begin
               period = saturate(longint'({32'd0, nominal}) - err);
               mode = MODE_START;
            end
         end else if (mode == MODE_TRACK) begin
            full = full_win || idx > DRIFT;
            k = full ? DRIFT : 1;
            sum = '0;
            time_ring[idx] = t;
            for (int i = 0; i < k; i++)
               sum += period_ring[(idx + RING - i) % RING];
            elapsed = t - time_ring[(idx + RING - k) % RING];
            if (elapsed == 0) begin
               did_reset = 1;
            end else begin
               base = rounded_base({64'd0, sum} * 128'd1000000000, elapsed);
               err += longint'({32'd0, period_ring[(idx + 1) % RING]}) - longint'(base);
               period = saturate(longint'(base) - err);
               period_ring[(idx + 2) % RING] = period;
               index = (idx + 1) % RING;
               full_win = full;
               if ((err < 0 ? -err : err) > longint'(err_limit)) did_reset = 1;
            end
            if (did_reset) begin
               period = nominal;
               index = 0;
               full_win = 0;
               mode = MODE_START;
            end
         end else begin
            period_ring[1] = nominal;
            mode = MODE_ACQUIRE;
         end
         w.period = period;
         w.mode = mode;
         w.did_reset = did_reset;
         owed.push_back(w);
      endfunction

      function void check_word(logic [31:0] period, logic [1:0] m, logic r);
         servo_word_type w;
         if (owed.size() == 0) begin
            $error("unexpected result word: next_period %0d", period);
            failures++;
            return;
         end
         w = owed.pop_front();
         if (period !== w.period) begin
            $error("next_period: expected %0d, got %0d", w.period, period);
            failures++;
         end
         if (m !== w.mode) begin
            $error("servo_mode: expected %0d, got %0d", w.mode, m);
            failures++;
         end
         if (r !== w.did_reset) begin
            $error("servo_reset: expected %0d, got %0d", w.did_reset, r);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pps_req_if req ();
   pps_rsp_if rsp ();

   servo_scoreboard board;

   // idle rates in percent for the sender and the receiver
   int send_idle;
   int recv_idle;
   // second count kept by the well-formed edge generator
   logic [63:0] seconds;

   pps_period_servo dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Receiver: random stalls on ready; each accepted word goes to the
   // scoreboard, sampled at the edge where it is taken.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready)
            board.check_word(rsp.next_period, rsp.servo_mode, rsp.servo_reset);
         rsp.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // APB write: setup cycle, access cycle until pready, then release.
   task automatic csr_write(logic [1:0] addr, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {addr, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.write_reg(addr, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one edge time; the prediction is made when the word is taken.
   // valid stays high after the accept; the next call or drain() sets it.
   task automatic send_edge(logic [63:0] t);
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.edge_time <= t;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.note_edge(t);
   endtask

   // Wait until every owed word has arrived, plus the idle tail.
   task automatic drain();
      req.valid <= 1'b0;
      while (board.owed.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // Edge near a whole second: one second later with a small phase offset.
   function automatic logic [63:0] near_second(int unsigned spread);
      longint signed off;
      seconds = seconds + 1;
      off = longint'($urandom_range(2 * spread)) - longint'(spread);
      return seconds * 64'd1000000000 + 64'(off);
   endfunction

   function automatic logic [63:0] any_edge();
      case ($urandom_range(3))
         0: return {$urandom, $urandom};
         1: return near_second(2000000);
         2: return near_second(40000);
         default: return seconds * 64'd1000000000 + 64'($urandom_range(999999999));
      endcase
   endfunction

   // Random phase: mostly well-formed pulse trains, some noise.
   task automatic random_phase(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 85) send_edge(near_second(($urandom_range(3) == 0) ? 900000
                                                                            : 20000));
         else send_edge(any_edge());
      end
   endtask

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.edge_time = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      board = new();
      board.clear_state();
      seconds = 64'd5;
      send_idle = 28;
      recv_idle = 86;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme timestamps, locked/unlocked acquire, zero elapsed
      // time, half-second fold boundaries.
      send_edge(64'd0);
      send_edge(64'hFFFF_FFFF_FFFF_FFFF);
      send_edge(64'd500000000);
      send_edge(64'd500000001);
      send_edge(64'd3000000000);
      send_edge(64'd4000000000);
      send_edge(64'd4000000000);          // zero elapsed time resets the servo
      send_edge(64'd6999999999);
      send_edge(64'd7000000000);
      send_edge(64'd8000000100);
      send_edge(64'd9000000050);
      send_edge(64'd9000800000);          // error beyond limit
      send_edge(64'hAAAA_AAAA_AAAA_AAAA);
      send_edge(64'h5555_5555_5555_5555);
      drain();

      // Extreme settings: nominal saturating, wide-open windows.
      csr_write(REG_NOMINAL, 32'hFFFF_FFFF);
      csr_write(REG_WINDOW, 32'd500000000);
      csr_write(REG_LIMIT, 32'd500000000);
      seconds = 64'd100;
      random_phase(250);
      drain();

      // Zero windows, nominal of one: acquire never locks; the sender then waits out every owed word.
      csr_write(REG_NOMINAL, 32'd1);
      csr_write(REG_WINDOW, 32'd0);
      csr_write(REG_LIMIT, 32'd0);
      for (int n = 0; n < 20; n++) send_edge(any_edge());
      drain();

      send_idle = 86;
      recv_idle = 28;
      csr_write(REG_NOMINAL, 32'd999990000);
      csr_write(REG_WINDOW, 32'd50000);
      csr_write(REG_LIMIT, 32'd1000000);
      random_phase(700);
      drain();

      send_idle = 0;
      recv_idle = 0;
      csr_write(REG_NOMINAL, 32'd1000000000);
      csr_write(REG_WINDOW, 32'd1000000);
      csr_write(REG_LIMIT, 32'd3000000);
      random_phase(900);
      drain();

      if (board.failures == 0 && board.owed.size() == 0) begin
         $display("pps_period_servo: match");
      end else begin
         $display("pps_period_servo: mismatch");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #40000000;
      $display("pps_period_servo: mismatch");
      $finish;
   end
endmodule

/* sim.f */
rtl/core/pps_pkg.sv
rtl/core/pps_if.sv
rtl/core/pps_ram.sv
rtl/core/pps_ctrl.sv
rtl/core/pps_datapath.sv
rtl/core/pps_period_servo.sv
sim/pps_period_servo_tb.sv
